// ===== rtl/core/msp_pkg.sv =====
// shared types, status byte codes and decode helpers for the midi stream parser
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package msp_pkg;

  localparam logic [7:0] ST_SYSEX_START  = 8'hF0;
  localparam logic [7:0] ST_TIME_CODE    = 8'hF1;
  localparam logic [7:0] ST_SONG_POS     = 8'hF2;
  localparam logic [7:0] ST_SONG_SELECT  = 8'hF3;
  localparam logic [7:0] ST_TUNE_REQUEST = 8'hF6;
  localparam logic [7:0] ST_SYSEX_END    = 8'hF7;
  localparam logic [7:0] ST_REALTIME_MIN = 8'hF8;

  localparam logic [3:0] HI_PROG_CHANGE  = 4'hC;
  localparam logic [3:0] HI_CHAN_PRESS   = 4'hD;
  localparam logic [3:0] HI_SYSTEM       = 4'hF;

  typedef struct packed {
    logic       valid;
    logic [7:0] status;
    logic [6:0] data1;
    logic [6:0] data2;
  } msg_t;

  function automatic logic [1:0] data_length(input logic [7:0] status);
    logic [1:0] len;
    case (status[7:4])
      HI_PROG_CHANGE, HI_CHAN_PRESS: len = 2'd1;
      HI_SYSTEM:                     len = (status == ST_SONG_POS) ? 2'd2 : 2'd1;
      default:                       len = 2'd2;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/midi_stream_parser.sv =====
// midi stream parser top level: input stage, running status parser, result register
// depends on msp_pkg, msp_in_stage, msp_parse, msp_out_reg
//
// usage
//   input channel: one midi byte per transaction on rx_byte (in_valid / in_ready)
//   output channel: one complete message per transaction on msg_status,
//   msg_data1, msg_data2 (out_valid / out_ready); unused data fields are zero
//   real-time bytes and tune request give a message at once; channel and
//   system common messages come out when their last data byte arrives, and
//   running status lets further data bytes repeat the last status
//   sysex data, undefined status bytes and data with no status give no message
//   path: input register, then decode into the result register, then out_valid
//   throughput: 1 byte per cycle unless the result register stalls, set by
//   the single decode stage between the input register and the result register
//   stall: while a message waits in the result register with out_ready low,
//   the input register still takes one more byte, then in_ready drops
//   reset: clears both registers' valid flags, running status, the data count
//   and the sysex flag
`timescale 1ns / 1ps
`default_nettype none

module midi_stream_parser (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      msg_status,
  output logic [6:0]      msg_data1,
  output logic [6:0]      msg_data2
);
  import msp_pkg::*;

  logic       take;
  logic       stage_valid;
  logic [7:0] stage_byte;
  msg_t       msg_next;

  msp_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .take       (take),
    .stage_valid(stage_valid),
    .stage_byte (stage_byte)
  );

  msp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .stage_byte(stage_byte),
    .msg_next  (msg_next)
  );

  msp_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .stage_valid(stage_valid),
    .msg_next   (msg_next),
    .take       (take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .msg_status (msg_status),
    .msg_data1  (msg_data1),
    .msg_data2  (msg_data2)
  );

endmodule

`default_nettype wire

// ===== rtl/core/msp_in_stage.sv =====
// input register stage: holds one received byte until the parser takes it
// depends on msp_pkg
`timescale 1ns / 1ps
`default_nettype none

module msp_in_stage (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  input  wire logic       take,
  output logic            stage_valid,
  output logic [7:0]      stage_byte
);
  import msp_pkg::*;

  assign in_ready = !stage_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_byte <= rx_byte;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/msp_parse.sv =====
// running status parser state and byte decode, one byte per transaction
// depends on msp_pkg
`timescale 1ns / 1ps
`default_nettype none

module msp_parse (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          take,
  input  wire logic [7:0]    stage_byte,
  output msp_pkg::msg_t      msg_next
);
  import msp_pkg::*;

  logic [7:0] running_status;
  logic [1:0] expected_count;
  logic       byte_index;
  logic [6:0] first_data;
  logic       in_sysex;

  logic [7:0] running_status_next;
  logic [1:0] expected_count_next;
  logic       byte_index_next;
  logic [6:0] first_data_next;
  logic       in_sysex_next;

  always_comb begin
    running_status_next = running_status;
    expected_count_next = expected_count;
    byte_index_next     = byte_index;
    first_data_next     = first_data;
    in_sysex_next       = in_sysex;
    msg_next            = '0;

    if (stage_byte[7]) begin
      if (stage_byte >= ST_REALTIME_MIN) begin
        msg_next.valid  = 1'b1;
        msg_next.status = stage_byte;
      end else if (stage_byte[7:4] == HI_SYSTEM) begin
        case (stage_byte)
          ST_SYSEX_START: in_sysex_next = 1'b1;
          ST_TIME_CODE, ST_SONG_POS, ST_SONG_SELECT: begin
            in_sysex_next       = 1'b0;
            running_status_next = stage_byte;
            byte_index_next     = 1'b0;
            expected_count_next = data_length(stage_byte);
          end
          ST_TUNE_REQUEST: begin
            in_sysex_next   = 1'b0;
            msg_next.valid  = 1'b1;
            msg_next.status = stage_byte;
          end
          ST_SYSEX_END: in_sysex_next = 1'b0;
          default: ;
        endcase
      end else begin
        in_sysex_next       = 1'b0;
        running_status_next = stage_byte;
        byte_index_next     = 1'b0;
        expected_count_next = data_length(stage_byte);
      end
    end else if (!in_sysex && expected_count != 2'd0) begin
      if (!byte_index) begin
        if (expected_count == 2'd1) begin
          msg_next.valid  = 1'b1;
          msg_next.status = running_status;
          msg_next.data1  = stage_byte[6:0];
        end else begin
          first_data_next = stage_byte[6:0];
          byte_index_next = 1'b1;
        end
      end else begin
        byte_index_next = 1'b0;
        msg_next.valid  = 1'b1;
        msg_next.status = running_status;
        msg_next.data1  = first_data;
        msg_next.data2  = stage_byte[6:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_status <= '0;
      expected_count <= '0;
      byte_index     <= 1'b0;
      first_data     <= '0;
      in_sysex       <= 1'b0;
    end else if (take) begin
      running_status <= running_status_next;
      expected_count <= expected_count_next;
      byte_index     <= byte_index_next;
      first_data     <= first_data_next;
      in_sysex       <= in_sysex_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/msp_out_reg.sv =====
// result register: holds one finished message until the receiver takes it
// depends on msp_pkg
`timescale 1ns / 1ps
`default_nettype none

module msp_out_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          stage_valid,
  input  msp_pkg::msg_t      msg_next,
  output logic               take,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         msg_status,
  output logic [6:0]         msg_data1,
  output logic [6:0]         msg_data2
);
  import msp_pkg::*;

  logic can_load;

  assign can_load = !out_valid || out_ready;
  assign take     = stage_valid && can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= take && msg_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && msg_next.valid) begin
      msg_status <= msg_next.status;
      msg_data1  <= msg_next.data1;
      msg_data2  <= msg_next.data2;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/msp_checker.sv =====
// port-level checks for the midi stream parser, bound to the top level
// depends on msp_pkg and midi_stream_parser
`timescale 1ns / 1ps
`default_nettype none

module msp_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] msg_status,
  input wire logic [6:0] msg_data1,
  input wire logic [6:0] msg_data2
);
  import msp_pkg::*;

  // stalled transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(msg_status)
      && $stable(msg_data1) && $stable(msg_data2))
    else $error("output transaction changed while stalled");

  a_rst_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_status_bit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> msg_status[7])
    else $error("message status without status bit");

  a_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && (msg_status >= ST_REALTIME_MIN || msg_status == ST_TUNE_REQUEST)
      |-> msg_data1 == 7'd0 && msg_data2 == 7'd0)
    else $error("data on a message that has none");

  a_one_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && (msg_status[7:4] == HI_PROG_CHANGE || msg_status[7:4] == HI_CHAN_PRESS
      || msg_status == ST_TIME_CODE || msg_status == ST_SONG_SELECT)
      |-> msg_data2 == 7'd0)
    else $error("second data byte on a one byte message");

endmodule

bind midi_stream_parser msp_checker u_msp_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .msg_status(msg_status),
  .msg_data1 (msg_data1),
  .msg_data2 (msg_data2)
);

`default_nettype wire

// ===== bench/tb_midi_stream_parser.sv =====
// testbench for midi_stream_parser: directed and random byte streams, scoreboard check
// depends on msp_pkg and the midi_stream_parser rtl
`timescale 1ns / 1ps

module tb_midi_stream_parser;
  import msp_pkg::*;

  localparam logic [3:0] HI_NOTE_OFF     = 4'h8;
  localparam logic [3:0] HI_NOTE_ON      = 4'h9;
  localparam logic [3:0] HI_CTRL_CHANGE  = 4'hB;
  localparam logic [3:0] HI_PITCH_BEND   = 4'hE;
  localparam logic [7:0] ST_UNDEF_F4     = 8'hF4;
  localparam logic [7:0] ST_UNDEF_F5     = 8'hF5;
  localparam logic [7:0] ST_REALTIME_MAX = 8'hFF;

  localparam int ITEM_TARGET = 1650;
  localparam int HOLD_CYCLES = 250;

  localparam logic [7:0] DIRECTED_SEQ [26] = '{
    8'h00, 8'h7F,
    {HI_NOTE_ON, 4'h0}, 8'h00, 8'h7F, 8'h7F, 8'h00,
    {HI_PROG_CHANGE, 4'hF}, 8'h55,
    ST_REALTIME_MIN,
    {HI_CTRL_CHANGE, 4'h3}, 8'h07,
    ST_SYSEX_START, 8'h12, ST_REALTIME_MAX, ST_TUNE_REQUEST, 8'h40,
    ST_SYSEX_END, ST_UNDEF_F4,
    ST_TIME_CODE, 8'h01,
    ST_SONG_POS, 8'h40, {HI_PITCH_BEND, 4'h0},
    ST_SONG_SELECT, 8'h05
  };

  typedef struct packed {
    logic [7:0] status;
    logic [6:0] data1;
    logic [6:0] data2;
  } midi_msg_t;

  class midi_scoreboard;
    logic [7:0] run_status;
    logic [1:0] data_count;
    logic [1:0] data_seen;
    logic [6:0] held_data;
    logic       sysex_on;
    midi_msg_t  pending_msgs[$];
    int         errors;

    function new();
      run_status = '0;
      data_count = '0;
      data_seen  = '0;
      held_data  = '0;
      sysex_on   = 1'b0;
      errors     = 0;
    endfunction

    task report(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    function void start_status(input logic [7:0] st);
      logic one_byte;
      one_byte = (st[7:4] == HI_PROG_CHANGE) || (st[7:4] == HI_CHAN_PRESS) ||
                 (st[7:4] == HI_SYSTEM && st != ST_SONG_POS);
      sysex_on   = 1'b0;
      run_status = st;
      data_seen  = '0;
      data_count = one_byte ? 2'd1 : 2'd2;
    endfunction

    // predict the message, if any, that one accepted byte completes
    function void note_byte(input logic [7:0] b);
      if (b[7]) begin
        if (b >= ST_REALTIME_MIN) begin
          pending_msgs.push_back('{b, 7'd0, 7'd0});
        end else if (b[7:4] == HI_SYSTEM) begin
          case (b)
            ST_SYSEX_START: sysex_on = 1'b1;
            ST_TIME_CODE, ST_SONG_POS, ST_SONG_SELECT: start_status(b);
            ST_TUNE_REQUEST: begin
              sysex_on = 1'b0;
              pending_msgs.push_back('{b, 7'd0, 7'd0});
            end
            ST_SYSEX_END: sysex_on = 1'b0;
            default: ;
          endcase
        end else begin
          start_status(b);
        end
      end else if (!sysex_on && data_count != 2'd0) begin
        if (data_seen == 2'd0 && data_count == 2'd1) begin
          pending_msgs.push_back('{run_status, b[6:0], 7'd0});
        end else if (data_seen == 2'd0) begin
          held_data = b[6:0];
          data_seen = 2'd1;
        end else begin
          data_seen = 2'd0;
          pending_msgs.push_back('{run_status, held_data, b[6:0]});
        end
      end
    endfunction

    task check_msg(input logic [7:0] st, input logic [6:0] d1, input logic [6:0] d2);
      midi_msg_t want;
      if (pending_msgs.size() == 0) begin
        report($sformatf("unexpected message %h %h %h", st, d1, d2));
      end else begin
        want = pending_msgs.pop_front();
        if (st !== want.status)
          report($sformatf("msg_status got %h want %h", st, want.status));
        if (d1 !== want.data1)
          report($sformatf("msg_data1 got %h want %h (status %h)", d1, want.data1, want.status));
        if (d2 !== want.data2)
          report($sformatf("msg_data2 got %h want %h (status %h)", d2, want.data2, want.status));
      end
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] msg_status;
  logic [6:0] msg_data1;
  logic [6:0] msg_data2;

  midi_scoreboard sb;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int hold_reqs = 0;
  int items_sent = 0;

  midi_stream_parser i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .msg_status (msg_status),
    .msg_data1  (msg_data1),
    .msg_data2  (msg_data2)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #400000;
    $display("FAIL midi_stream_parser");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (rst) begin
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (rx_idle_on) begin
        out_ready <= ($urandom_range(99) >= 24);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_msg(msg_status, msg_data1, msg_data2);
  end

  task automatic send_byte(input logic [7:0] b);
    while (tx_idle_on && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(b);
    items_sent++;
  endtask

  task automatic send_realtime();
    send_byte(8'($urandom_range(ST_REALTIME_MAX, ST_REALTIME_MIN)));
  endtask

  // data byte, sometimes preceded by an interleaved real-time byte
  task automatic send_data();
    if ($urandom_range(99) < 5)
      send_realtime();
    send_byte(8'($urandom_range(127)));
  endtask

  task automatic send_random_group();
    int kind;
    int msgs;
    int nbytes;
    int m;
    int k;
    logic [7:0] st;
    kind = $urandom_range(99);
    if (kind < 55) begin
      st = {4'($urandom_range(HI_PITCH_BEND, HI_NOTE_OFF)), 4'($urandom_range(15))};
      nbytes = (st[7:4] == HI_PROG_CHANGE || st[7:4] == HI_CHAN_PRESS) ? 1 : 2;
      msgs = $urandom_range(4, 1);
      send_byte(st);
      for (m = 0; m < msgs; m++) begin
        for (k = 0; k < nbytes; k++) begin
          // occasionally cut the last message short
          if (!(m == msgs - 1 && k == nbytes - 1 && $urandom_range(99) < 10))
            send_data();
        end
      end
    end else if (kind < 65) begin
      st = 8'($urandom_range(ST_SONG_SELECT, ST_TIME_CODE));
      nbytes = (st == ST_SONG_POS) ? 2 : 1;
      msgs = $urandom_range(2, 1);
      send_byte(st);
      for (m = 0; m < msgs * nbytes; m++)
        send_data();
    end else if (kind < 75) begin
      if ($urandom_range(3) == 0)
        send_byte(ST_TUNE_REQUEST);
      else
        send_realtime();
    end else if (kind < 85) begin
      send_byte(ST_SYSEX_START);
      nbytes = $urandom_range(6);
      for (m = 0; m < nbytes; m++)
        send_data();
      if ($urandom_range(3) != 0)
        send_byte(ST_SYSEX_END);
    end else begin
      nbytes = $urandom_range(4, 1);
      for (m = 0; m < nbytes; m++)
        send_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic wait_drained();
    while (sb.pending_msgs.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    int i;
    bit quiet_done;
    bit hold_done;
    bit drain_done;
    quiet_done = 1'b0;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < 26; i++)
      send_byte(DIRECTED_SEQ[i]);

    while (items_sent < ITEM_TARGET) begin
      if (!quiet_done && items_sent >= 300) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      if (!quiet_done && items_sent >= 700) begin
        quiet_done = 1'b1;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
      end
      if (!hold_done && items_sent >= 1000) begin
        // back-pressure: receiver holds off while bytes keep coming
        hold_done  = 1'b1;
        tx_idle_on = 1'b0;
        hold_reqs++;
        for (i = 0; i < 80; i++)
          send_realtime();
        tx_idle_on = 1'b1;
      end
      if (!drain_done && items_sent >= 1300) begin
        drain_done = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        wait_drained();
      end
      send_random_group();
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS midi_stream_parser");
    end else begin
      $display("FAIL midi_stream_parser");
    end
    $finish;
  end

endmodule
